// File: rtl/core/apsu_pkg.sv
// Shared types and constants for the anemometer period speed unit.
// Used by every module of the block but apsu_queue; depends on nothing else.
`default_nettype none

package apsu_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned SPEED_W = 32;

	typedef enum logic [1:0] {
		REG_PULSES_PER_REV = 2'd0,
		REG_WARMUP_COUNT   = 2'd1,
		REG_SPEED_SCALE    = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_index_t;

	typedef enum logic {
		OP_CAPTURE = 1'b0,
		OP_REARM   = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [7:0]         pulses_per_rev;
		logic [7:0]         warmup_count;
		logic [SPEED_W-1:0] speed_scale;
	} cfg_t;

	localparam logic [7:0] PULSES_PER_REV_RST = 8'd2;
	localparam logic [7:0] WARMUP_COUNT_RST   = 8'd4;
	localparam logic [SPEED_W-1:0] SPEED_SCALE_RST = '0;
	// The edge counter starts at twice the reset edges per revolution.
	localparam logic [7:0] EDGE_COUNT_RST = 8'(2 * PULSES_PER_REV_RST);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} div_state_t;

endpackage

`default_nettype wire

// File: rtl/core/apsu_regs.sv
// Configuration register file behind the APB-style port.
// Depends on apsu_pkg for the register map and the configuration struct.
`default_nettype none

module apsu_regs
	import apsu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	reg_index_t index;
	logic       write_en;

	assign index    = reg_index_t'(paddr[ADDR_W-1:2]);
	assign write_en = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulses_per_rev <= PULSES_PER_REV_RST;
			cfg_q.warmup_count   <= WARMUP_COUNT_RST;
			cfg_q.speed_scale    <= SPEED_SCALE_RST;
		end else if (write_en) begin
			unique case (index)
				REG_PULSES_PER_REV: cfg_q.pulses_per_rev <= pwdata[7:0];
				REG_WARMUP_COUNT:   cfg_q.warmup_count   <= pwdata[7:0];
				REG_SPEED_SCALE:    cfg_q.speed_scale    <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_PULSES_PER_REV: prdata = {24'd0, cfg_q.pulses_per_rev};
			REG_WARMUP_COUNT:   prdata = {24'd0, cfg_q.warmup_count};
			REG_SPEED_SCALE:    prdata = cfg_q.speed_scale;
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/apsu_front.sv
// Front end: accepts edge and rearm transactions, counts edges and revolutions,
// and queues the period of each revolution that is published. Uses apsu_pkg.
`default_nettype none

module apsu_front
	import apsu_pkg::*;
#(
	parameter int unsigned STAMP_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   opcode,
	input  wire logic [31:0]            timestamp,
	input  wire cfg_t                   cfg,
	output logic                        push,
	output logic      [STAMP_WIDTH-1:0] push_period,
	input  wire logic                   queue_full
);

	logic [7:0]             edge_count_q;
	logic [7:0]             warm_count_q;
	logic [STAMP_WIDTH-1:0] last_stamp_q;
	logic                   armed_q;

	logic [STAMP_WIDTH+31:0] stamp_wide;
	logic [STAMP_WIDTH-1:0]  stamp;
	logic [7:0]              edge_next;
	logic [7:0]              warm_next;
	logic                    accept;
	logic                    is_edge;
	logic                    rev_done;
	logic                    publish;

	// Timestamps are taken modulo 2^STAMP_WIDTH.
	assign stamp_wide = {{STAMP_WIDTH{1'b0}}, timestamp};
	assign stamp      = stamp_wide[STAMP_WIDTH-1:0];

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	assign is_edge   = accept && (opcode_t'(opcode) == OP_CAPTURE) && armed_q;
	assign edge_next = edge_count_q + 8'd1;
	assign warm_next = warm_count_q + 8'd1;
	assign rev_done  = is_edge && (edge_next >= cfg.pulses_per_rev);
	assign publish   = rev_done && (warm_next == cfg.warmup_count);

	assign push        = publish;
	assign push_period = stamp - last_stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= EDGE_COUNT_RST;
			warm_count_q <= 8'd0;
			last_stamp_q <= '0;
			armed_q      <= 1'b1;
		end else if (accept) begin
			if (opcode_t'(opcode) == OP_REARM) begin
				armed_q <= 1'b1;
			end else if (is_edge) begin
				if (!rev_done) begin
					edge_count_q <= edge_next;
				end else begin
					edge_count_q <= 8'd0;
					last_stamp_q <= stamp;
					if (publish) begin
						warm_count_q <= 8'd0;
						armed_q      <= 1'b0;
					end else begin
						warm_count_q <= warm_next;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/apsu_queue.sv
// Two-entry queue of periods between the front end and the divider.
// Standalone apart from the shared net type conventions.
`default_nettype none

module apsu_queue #(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic      [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/apsu_back.sv
// Back end: a restoring divider, one quotient bit a cycle, that turns a period
// into speed_scale / period, and the output register. Uses apsu_pkg.
`default_nettype none

module apsu_back
	import apsu_pkg::*;
#(
	parameter int unsigned STAMP_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	output logic                        job_ready,
	input  wire logic [STAMP_WIDTH-1:0] job_period,
	input  wire logic [SPEED_W-1:0]     speed_scale,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [SPEED_W-1:0]     speed
);

	localparam int unsigned CNT_W = $clog2(SPEED_W);

	div_state_t state_q;
	div_state_t state_next;

	logic [STAMP_WIDTH-1:0] divisor_q;
	logic [STAMP_WIDTH-1:0] rem_q;
	logic [SPEED_W-1:0]     quot_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic [SPEED_W-1:0]     speed_q;

	logic [STAMP_WIDTH:0] trial;
	logic                 fits;
	logic                 out_free;
	logic                 start;
	logic                 load_out;

	// A zero divisor makes every trial fit, so the quotient saturates to all ones.
	assign trial    = {rem_q, quot_q[SPEED_W-1]};
	assign fits     = trial >= {1'b0, divisor_q};
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (job_valid) state_next = ST_DIVIDE;
			ST_DIVIDE: if (count_q == CNT_W'(SPEED_W - 1)) state_next = ST_FINISH;
			ST_FINISH: if (out_free) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:   job_ready = 1'b1;
			ST_DIVIDE: ;
			ST_FINISH: load_out = out_free;
			default:   ;
		endcase
	end

	assign start = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (start) begin
				count_q <= '0;
			end else if (state_q == ST_DIVIDE) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= job_period;
			rem_q     <= '0;
			quot_q    <= speed_scale;
		end else if (state_q == ST_DIVIDE) begin
			if (fits) begin
				rem_q <= STAMP_WIDTH'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[STAMP_WIDTH-1:0];
			end
			quot_q <= {quot_q[SPEED_W-2:0], fits};
		end
		if (load_out) begin
			speed_q <= quot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign speed     = speed_q;

endmodule

`default_nettype wire

// File: rtl/core/anemometer_period_speed_unit.sv
// Anemometer period speed unit: top level joining registers, front end, queue
// and divider. Depends on apsu_pkg and the apsu_* modules.
`default_nettype none

// Each capture transaction is handled by the front end in the cycle it is
// accepted; edges while disarmed and rearm transactions leave no result. When
// warmup_count revolutions are complete, the period of the last one goes
// through a two-entry queue to a restoring divider that produces one quotient
// bit per cycle. The period is registered in the queue, taken by the idle
// divider, divided in 32 steps and then loaded into the output register once
// that register is free. The divider takes a new period only when it is idle;
// input transactions are taken whenever the queue has room. A zero period
// yields 0xFFFFFFFF. STAMP_WIDTH sets the timer width used for the period.

module anemometer_period_speed_unit
	import apsu_pkg::*;
#(
	parameter int unsigned STAMP_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              opcode,
	input  wire logic [31:0]       timestamp,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [SPEED_W-1:0] speed
);

	cfg_t                   cfg;
	logic                   push;
	logic [STAMP_WIDTH-1:0] push_period;
	logic                   queue_full;
	logic                   job_valid;
	logic                   job_ready;
	logic [STAMP_WIDTH-1:0] job_period;

	apsu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apsu_front #(
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.timestamp   (timestamp),
		.cfg         (cfg),
		.push        (push),
		.push_period (push_period),
		.queue_full  (queue_full)
	);

	apsu_queue #(
		.WIDTH (STAMP_WIDTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_period),
		.full      (queue_full),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_data  (job_period)
	);

	apsu_back #(
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job_period  (job_period),
		.speed_scale (cfg.speed_scale),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.speed       (speed)
	);

endmodule

`default_nettype wire
